### src/hta_pkg.sv
// Shared types, constants and helper functions for the handle table allocator.
`default_nettype none
package hta_pkg;

  // Table geometry.
  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int LINK_W      = $clog2(MAX_ENTRIES + 1);

  // Fixed field widths of the handle format and the size register.
  localparam int SIZE_W      = 7;
  localparam int GEN_W       = 15;
  localparam int IDXF_W      = 15;
  localparam int HOUT_W      = GEN_W + IDXF_W;
  localparam int WORD_W      = 32;

  localparam logic [SIZE_W-1:0] DEFAULT_SIZE = 7'h28;

  // Operation codes.
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLOSE  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [WORD_W-1:0] object_ref;
    logic [WORD_W-1:0] handle_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [HOUT_W-1:0] new_handle;
    logic [WORD_W-1:0] object_out;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming transaction and read the table
    logic commit;    // update the table and load the result register
    logic rebuild;   // size register write: rebuild an empty table
  } hta_cmd_t;

  // Size in use: zero selects the default, large values saturate.
  function automatic logic [LINK_W-1:0] eff_size(input logic [SIZE_W-1:0] ts);
    int s;
    s = (ts == '0) ? int'(DEFAULT_SIZE) : int'(ts);
    if (s > MAX_ENTRIES) begin
      s = MAX_ENTRIES;
    end
    return LINK_W'(s);
  endfunction

endpackage
`default_nettype wire

### src/handle_table_allocator_top.sv
// Top level of the handle table allocator: controller, datapath and checks.
// Usage:
// The input channel (in_valid, in_ready, in_item) carries one transaction per
// operation: create, look up or close. The result channel (out_valid,
// out_ready, out_item) returns exactly one result transaction per input
// transaction, in order, with a status, a new handle or a found reference.
// The configuration channel (cfg_valid, cfg_ready, cfg_table_size) writes the
// table size; every write empties the table, relinks the free list in index
// order and restarts the generation count. It is always ready and must only
// be used while no operation is outstanding.
// Timing: an accepted transaction's table entry and free-list link are read
// at the accepting edge; its result is registered once the output register
// is free, which a receiver stall can delay, and out_valid rises with it.
// One operation is in flight at a time; the read-then-write of the single
// table port means a new transaction is taken only after the last commits.
// A receiver stall holds the operation in the execute step while the previous
// result waits in the output register, so input acceptance then pauses.
// Reset (rst_n low, synchronous) empties the table with a size of forty and
// clears the generation count; no table memory is swept, so the block is
// ready as soon as reset is released.
`default_nettype none
module handle_table_allocator_top
  import hta_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_item,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_table_size
);

  hta_cmd_t cmd;

  hta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  hta_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_item        (in_item),
    .cfg_table_size (cfg_table_size),
    .out_item       (out_item)
  );

  // Only one operation is in flight: in_ready is low in the cycle after an acceptance.
  a_one_in_flight : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an operation was in flight");

  // A rise of out_valid traces back to a capture through the state and output valid registers.
  a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.capture, 2))
    else $error("result produced without a matching input transaction");

  // Failed operations return zero handle and zero reference.
  a_fail_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status != ST_OK)) |->
      ((out_item.new_handle == '0) && (out_item.object_out == '0)))
    else $error("failed operation returned non-zero payload");

  // A commit never coincides with a new capture.
  a_cmd_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");

endmodule
`default_nettype wire

### src/hta_ctrl.sv
// Controller state machine of the handle table allocator.
`default_nettype none
module hta_ctrl
  import hta_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  output hta_cmd_t      cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.capture = (state_r == S_IDLE) && in_valid;
    // The result register must be free, or emptied in this cycle.
    cmd.commit  = (state_r == S_EXEC) && (!out_valid_r || out_ready);
    cmd.rebuild = cfg_valid;

    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = 1'b1;

endmodule
`default_nettype wire

### src/hta_dp.sv
// Datapath of the handle table allocator: table memories, free list and result register.
`default_nettype none
module hta_dp
  import hta_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hta_cmd_t          cmd,
  input  wire in_item_t          in_item,
  input  wire logic [SIZE_W-1:0] cfg_table_size,
  output out_item_t              out_item
);

  // Table memories; handle and object words are undefined until written.
  logic [HOUT_W-1:0] handle_mem [MAX_ENTRIES];
  logic [WORD_W-1:0] object_mem [MAX_ENTRIES];
  logic [LINK_W-1:0] link_mem   [MAX_ENTRIES];

  logic [HOUT_W-1:0] handle_rd_r;
  logic [WORD_W-1:0] object_rd_r;
  logic [LINK_W-1:0] link_rd_r;

  // Per-entry flags; a link whose flag is clear reads as its rebuilt value.
  logic [MAX_ENTRIES-1:0] live_r, live_nxt;
  logic [MAX_ENTRIES-1:0] lnkv_r, lnkv_nxt;

  logic [LINK_W-1:0] head_r, head_nxt;
  logic [GEN_W-1:0]  gen_r, gen_nxt;
  logic [SIZE_W-1:0] size_r;

  logic [1:0]        op_r;
  logic [WORD_W-1:0] obj_r;
  logic [WORD_W-1:0] h_r;
  out_item_t         out_r, res;

  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  head_addr;
  logic [IDX_W-1:0]  h_addr;
  logic [LINK_W-1:0] eff;
  logic [LINK_W:0]   head_inc;
  logic [LINK_W-1:0] link_def;
  logic [LINK_W-1:0] next_link;
  logic [GEN_W-1:0]  gen_inc;
  logic              full;
  logic              hit;
  logic              do_create;
  logic              do_close;

  assign rd_addr = (in_item.operation == OP_CREATE) ? head_r[IDX_W-1:0]
                                                    : in_item.handle_in[IDX_W-1:0];

  always_comb begin
    eff       = eff_size(size_r);
    head_addr = head_r[IDX_W-1:0];
    h_addr    = h_r[IDX_W-1:0];
    full      = (head_r >= eff);
    head_inc  = {1'b0, head_r} + (LINK_W+1)'(1);
    link_def  = (head_inc < {1'b0, eff}) ? head_inc[LINK_W-1:0] : eff;
    next_link = lnkv_r[head_addr] ? link_rd_r : link_def;
    gen_inc   = gen_r + GEN_W'(1);
    hit       = (h_r[IDXF_W-1:0] < IDXF_W'(eff)) && live_r[h_addr]
                && (h_r[WORD_W-1:HOUT_W] == '0) && (handle_rd_r == h_r[HOUT_W-1:0]);

    do_create = 1'b0;
    do_close  = 1'b0;
    res.status     = ST_BAD;
    res.new_handle = '0;
    res.object_out = '0;
    case (op_r)
      OP_CREATE: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          do_create      = 1'b1;
          res.status     = ST_OK;
          res.new_handle = {gen_inc, IDXF_W'(head_addr)};
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          res.status     = ST_OK;
          res.object_out = object_rd_r;
        end
      end
      OP_CLOSE: begin
        if (hit) begin
          do_close   = 1'b1;
          res.status = ST_OK;
        end
      end
      default: res.status = ST_BAD;
    endcase

    live_nxt = live_r;
    lnkv_nxt = lnkv_r;
    head_nxt = head_r;
    gen_nxt  = gen_r;
    if (cmd.commit && do_create) begin
      live_nxt[head_addr] = 1'b1;
      head_nxt            = next_link;
      gen_nxt             = gen_inc;
    end
    if (cmd.commit && do_close) begin
      live_nxt[h_addr] = 1'b0;
      lnkv_nxt[h_addr] = 1'b1;
      head_nxt         = LINK_W'(h_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      lnkv_r <= '0;
      head_r <= '0;
      gen_r  <= '0;
      size_r <= DEFAULT_SIZE;
    end else if (cmd.rebuild) begin
      live_r <= '0;
      lnkv_r <= '0;
      head_r <= '0;
      gen_r  <= '0;
      size_r <= cfg_table_size;
    end else begin
      live_r <= live_nxt;
      lnkv_r <= lnkv_nxt;
      head_r <= head_nxt;
      gen_r  <= gen_nxt;
    end
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (cmd.commit && do_create) begin
      handle_mem[head_addr] <= res.new_handle;
      object_mem[head_addr] <= obj_r;
    end
    if (cmd.commit && do_close) begin
      link_mem[h_addr] <= head_r;
    end
    if (cmd.capture) begin
      handle_rd_r <= handle_mem[rd_addr];
      object_rd_r <= object_mem[rd_addr];
      link_rd_r   <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_item.operation;
      obj_r <= in_item.object_ref;
      h_r   <= in_item.handle_in;
    end
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  assign out_item = out_r;

endmodule
`default_nettype wire

### verif/handle_table_allocator_top_tb.sv
// Self-checking testbench for the handle table allocator, with its own table predictor.
`timescale 1ns / 100ps
module handle_table_allocator_top_tb;
  import hta_pkg::*;

  // Operation code that the block does not implement; it must be rejected as a bad handle.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // The receiver holds off once for this many cycles, starting when this transaction is
  // accepted, so that the block fills up and stops taking input.
  localparam int HOLD_AT  = 400;
  localparam int HOLD_LEN = 400;

  // The limit stands well above the slowest correct run: some 1500 transactions, each with
  // a drawn wait on either side, plus the long hold-off and the gaps around size writes.
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int REPORT_LIMIT = 100;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [SIZE_W-1:0]   cfg_table_size = '0;

  handle_table_allocator_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_table_size (cfg_table_size)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------
  // Table predictor. It mirrors the handle table: stored handle and object per entry, the
  // live marks, the singly linked free list, its head and the generation count. It is
  // advanced once per accepted input transaction, in acceptance order.
  // ---------------------------------------------------------------------------------------
  logic [SIZE_W-1:0] size_reg;
  logic [HOUT_W-1:0] tbl_hdl  [MAX_ENTRIES];
  logic [WORD_W-1:0] tbl_obj  [MAX_ENTRIES];
  bit                tbl_live [MAX_ENTRIES];
  logic [LINK_W-1:0] link     [MAX_ENTRIES];
  logic [LINK_W-1:0] head;
  logic [GEN_W-1:0]  gen_count;

  in_item_t  pending_ops [$];   // transactions waiting for the input driver
  out_item_t results_due [$];   // predicted results, oldest first
  int        errors = 0;
  int        taken = 0;         // accepted input transactions
  int        cycles = 0;
  int        hold_left = 0;
  bit        calm = 1'b0;       // when set, neither side idles

  // Entries in use: a size of zero selects the default, anything above the table saturates.
  function automatic int active_size();
    int n;
    n = (size_reg == '0) ? int'(DEFAULT_SIZE) : int'(size_reg);
    return (n > MAX_ENTRIES) ? MAX_ENTRIES : n;
  endfunction

  // A size write empties the table, relinks every entry in index order and restarts the
  // generation count. The last entry in use points at the size, which marks the list end.
  function automatic void rebuild_model(input logic [SIZE_W-1:0] v);
    int n;
    size_reg = v;
    n = active_size();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      tbl_live[i] = 1'b0;
      link[i] = LINK_W'((i + 1 < n) ? i + 1 : n);
    end
    head = '0;
    gen_count = '0;
  endfunction

  // True when the handle names a live entry below the size and matches it in all 32 bits,
  // so that set bits 31:30 never match.
  function automatic bit handle_is_live(input logic [WORD_W-1:0] h, output int ix);
    ix = int'(h[IDXF_W-1:0]);
    if (ix >= active_size()) begin
      return 1'b0;
    end
    return tbl_live[ix] && ({2'b00, tbl_hdl[ix]} == h);
  endfunction

  function automatic out_item_t apply_op(input in_item_t it);
    out_item_t r;
    int        ix;
    r = '0;
    r.status = ST_BAD;
    case (it.operation)
      OP_CREATE: begin
        if (head >= active_size()) begin
          r.status = ST_FULL;
        end else begin
          ix = int'(head);
          head = link[ix];
          gen_count = gen_count + 1'b1;
          r.new_handle = {gen_count, IDXF_W'(ix)};
          tbl_hdl[ix] = r.new_handle;
          tbl_obj[ix] = it.object_ref;
          tbl_live[ix] = 1'b1;
          r.status = ST_OK;
        end
      end
      OP_LOOKUP: begin
        if (handle_is_live(it.handle_in, ix)) begin
          r.object_out = tbl_obj[ix];
          r.status = ST_OK;
        end
      end
      OP_CLOSE: begin
        if (handle_is_live(it.handle_in, ix)) begin
          tbl_live[ix] = 1'b0;
          link[ix] = head;
          head = LINK_W'(ix);
          r.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Mismatch reports are capped so that a badly broken block cannot flood the log.
  function automatic void report(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
    errors++;
    if (errors <= REPORT_LIMIT) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      report("unexpected result transaction", '0, WORD_W'(got.status));
      return;
    end
    want = results_due.pop_front();
    if (got.status !== want.status) begin
      report("status", WORD_W'(want.status), WORD_W'(got.status));
    end
    if (got.new_handle !== want.new_handle) begin
      report("new_handle", WORD_W'(want.new_handle), WORD_W'(got.new_handle));
    end
    if (got.object_out !== want.object_out) begin
      report("object_out", want.object_out, got.object_out);
    end
  endfunction

  // Each side draws a random wait per transaction, except during calm stretches.
  function automatic int draw_wait();
    return calm ? 0 : int'($urandom_range(0, 11));
  endfunction

  // ---------------------------------------------------------------------------------------
  // Input driver. The predictor runs at the edge where a transaction is accepted. The wait
  // drawn for a transaction is spent after it has been accepted, before the next one is
  // offered; while valid is up nothing changes until the block takes it.
  // ---------------------------------------------------------------------------------------
  int in_wait = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        results_due.push_back(apply_op(in_item));
        taken <= taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (in_wait != 0) begin
          in_valid <= 1'b0;
          in_wait <= in_wait - 1;
        end else if (pending_ops.size() != 0) begin
          in_item <= pending_ops.pop_front();
          in_valid <= 1'b1;
          in_wait <= draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result monitor. Every accepted result transaction is checked against the oldest
  // prediction; after each one the receiver may stall for a drawn number of cycles, and it
  // also stays stalled while the long hold-off runs.
  // ---------------------------------------------------------------------------------------
  int out_wait = 0;

  always @(posedge clk) begin : watch_results
    int w;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait <= 0;
    end else begin
      w = out_wait;
      if (out_valid && out_ready) begin
        check_result(out_item);
        w = draw_wait();
      end else if (w != 0) begin
        w = w - 1;
      end
      out_wait <= w;
      out_ready <= (w == 0) && (hold_left == 0);
    end
  end

  // The long receiver hold-off, counted here; the driver keeps offering during it.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (in_valid && in_ready && taken == HOLD_AT) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus. Queue and predictor accesses here happen on the falling edge, away from the
  // driver and monitor, which act on the rising edge, except the rebuild in write_size.
  // ---------------------------------------------------------------------------------------
  task automatic offer(input logic [1:0] op, input logic [WORD_W-1:0] obj,
                       input logic [WORD_W-1:0] h);
    in_item_t it;
    do @(negedge clk); while (pending_ops.size() >= 3);
    it.operation = op;
    it.object_ref = obj;
    it.handle_in = h;
    pending_ops.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_ops.size() != 0 || in_valid || results_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // The size register is only written with nothing in flight. Every transaction returns a
  // result, so once the last result is in, nothing is left in flight.
  task automatic write_size(input logic [SIZE_W-1:0] v);
    wait_idle();
    repeat (2) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_table_size <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rebuild_model(v);
    @(negedge clk);
  endtask

  // Handle for a look up or close. Most are live handles taken from the predicted table;
  // the rest are stale generations, indexes beyond the size, set top bits and plain noise.
  // Because the generator runs a few transactions ahead, some live picks go stale anyway.
  function automatic logic [WORD_W-1:0] pick_handle();
    int                n;
    int                ix;
    int                j;
    int                sel;
    bit                found;
    logic [WORD_W-1:0] h;
    n = active_size();
    ix = $urandom_range(0, n - 1);
    sel = $urandom_range(0, 99);
    found = 1'b0;
    j = 0;
    while (!found && j < n) begin
      if (tbl_live[(ix + j) % n]) begin
        ix = (ix + j) % n;
        found = 1'b1;
      end
      j++;
    end
    h = found ? {2'b00, tbl_hdl[ix]} : {2'b00, gen_count, IDXF_W'(ix)};
    if (sel < 60) begin
      if (!found) begin
        h = $urandom;
      end
    end else if (sel < 70) begin
      h[$urandom_range(IDXF_W, HOUT_W - 1)] ^= 1'b1;
    end else if (sel < 80) begin
      h = $urandom;
      h[IDXF_W-1:0] = IDXF_W'($urandom_range(n, 32767));
    end else if (sel < 90) begin
      h[WORD_W-1:HOUT_W] = 2'($urandom_range(1, 3));
    end else begin
      h = $urandom;
    end
    return h;
  endfunction

  initial begin : stimulus
    int               seg;
    int               i;
    int               sel;
    int               create_pct;
    logic [1:0]       op;

    for (int e = 0; e < MAX_ENTRIES; e++) begin
      tbl_hdl[e] = '0;
      tbl_obj[e] = '0;
    end
    rebuild_model(DEFAULT_SIZE);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size of forty. Handles are generation << 15 | index.
    offer(OP_LOOKUP, 32'h0, 32'h0);                 // nothing live yet
    offer(OP_CLOSE, 32'h0, 32'h0);
    offer(OP_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // generation 1, entry 0
    offer(OP_CREATE, 32'h0, 32'h0);                 // generation 2, entry 1
    offer(OP_LOOKUP, 32'h0, 32'h0000_8000);
    offer(OP_LOOKUP, 32'h0, 32'h4000_8000);         // bit 30 set never matches
    offer(OP_LOOKUP, 32'h0, 32'h8000_8000);         // nor does bit 31
    offer(OP_LOOKUP, 32'h0, 32'h0001_0000);         // right entry, wrong generation
    offer(OP_LOOKUP, 32'h0, 32'h0000_0028);         // index equal to the size
    offer(OP_LOOKUP, 32'h0, 32'hFFFF_7FFF);         // highest index, all bits but 15 set
    offer(OP_UNUSED, 32'hFFFF_FFFF, 32'h0000_8000); // unused operation, live handle
    offer(OP_CLOSE, 32'h0, 32'h0000_8000);
    offer(OP_CLOSE, 32'h0, 32'h0000_8000);          // double close
    offer(OP_LOOKUP, 32'h0, 32'h0000_8000);         // stale after the close
    offer(OP_CREATE, 32'h1234_5678, 32'h0);         // reuses entry 0 from the list head

    // A single entry: fill, report full, free and refill.
    write_size(7'd1);
    offer(OP_CREATE, 32'hA5A5_A5A5, 32'h0);
    offer(OP_CREATE, 32'h5A5A_5A5A, 32'h0);         // table full
    offer(OP_CLOSE, 32'h0, 32'h0000_8000);
    offer(OP_CREATE, 32'h0F0F_0F0F, 32'h0);
    offer(OP_LOOKUP, 32'h0, 32'h0001_0000);

    // Random part: ten segments of 150 transactions, each with its own size, mix of
    // operations and idling. The first four segments pin the size extremes.
    for (seg = 0; seg < 10; seg++) begin
      case (seg)
        0: write_size(7'd127);
        1: write_size(7'd0);
        2: write_size(7'd2);
        3: write_size(7'd64);
        default: begin
          sel = $urandom_range(0, 3);
          if (sel == 0) begin
            write_size(SIZE_W'($urandom_range(1, 4)));
          end else if (sel == 1) begin
            write_size(SIZE_W'($urandom_range(65, 127)));
          end else begin
            write_size(SIZE_W'($urandom_range(0, 64)));
          end
        end
      endcase
      calm = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 2);
      create_pct = (sel == 0) ? 20 : (sel == 1) ? 50 : 80;
      for (i = 0; i < 150; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          op = OP_UNUSED;
        end else if (sel < 5 + create_pct) begin
          op = OP_CREATE;
        end else if (sel < 5 + create_pct + (95 - create_pct) / 2) begin
          op = OP_LOOKUP;
        end else begin
          op = OP_CLOSE;
        end
        offer(op, $urandom, (op == OP_CREATE) ? $urandom : pick_handle());
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
src/hta_pkg.sv
src/hta_ctrl.sv
src/hta_dp.sv
src/handle_table_allocator_top.sv
verif/handle_table_allocator_top_tb.sv
